### design/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg: shared types and codes for the limit order matcher
// Holds the order and report structs and the error and report codes.
// ----------------------------------------------------------------------------
package lom_pkg;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_BAD_ID    = 3'd1;
   localparam logic [2:0] ERR_BAD_SIDE  = 3'd2;
   localparam logic [2:0] ERR_BAD_SYM   = 3'd3;
   localparam logic [2:0] ERR_BAD_PRICE = 3'd4;
   localparam logic [2:0] ERR_BAD_QTY   = 3'd5;
   localparam logic [2:0] ERR_BOOK_FULL = 3'd6;

   localparam logic RES_TRADE  = 1'b0;
   localparam logic RES_INSERT = 1'b1;

   localparam logic [1:0] SIDE_BUY  = 2'd0;
   localparam logic [1:0] SIDE_SELL = 2'd1;

   typedef struct packed {
      logic [31:0]        order_ident;
      logic [1:0]         side;
      logic [1:0]         symbol_ident;
      logic signed [31:0] quantity;
      logic signed [31:0] limit_price;
   } req_type;

   typedef struct packed {
      logic               result_type;
      logic [1:0]         out_symbol;
      logic [31:0]        out_order_ident;
      logic [31:0]        resting_ident;
      logic signed [31:0] out_quantity;
      logic signed [31:0] out_price;
      logic [2:0]         error_code;
      logic               is_last;
   } rsp_type;

   // one resting order as seen by the compare unit
   typedef struct packed {
      logic        valid;
      logic [30:0] price;
      logic [31:0] age;
   } cand_type;

endpackage

### design/lom_cmp.sv
// ----------------------------------------------------------------------------
// lom_cmp: price-time priority compare
// Decides whether a resting candidate may trade and beats the current best.
// ----------------------------------------------------------------------------
module lom_cmp (
   input  lom_pkg::cand_type  cand,
   input  lom_pkg::cand_type  best,
   input  logic               is_sell,
   input  logic signed [31:0] limit,
   output logic               take
);
   logic [31:0] cp;
   logic        eligible;
   logic        better;

   always_comb begin
      cp       = {1'b0, cand.price};
      // limit is known positive here, so an unsigned compare is exact
      eligible = cand.valid && (is_sell ? (cp >= limit) : (cp <= limit));
      better   = (is_sell ? (cand.price > best.price) : (cand.price < best.price))
                 || ((cand.price == best.price) && (cand.age > best.age));
      take     = eligible && (!best.valid || better);
   end
endmodule

### design/limit_order_matcher_core.sv
// ----------------------------------------------------------------------------
// limit_order_matcher_core: price-time priority limit order book
// An order takes an accept step, scans of the opposite side and a trade step per fill:
// one scan per fill plus a final one unless the last fill uses the order up, no scan
// for a rejected order, then a report step. Result stalls stretch the trade and report
// steps. One order in flight at a time; reset (synchronous, active high) empties the
// book (valid flops) and clears the counter.
// ----------------------------------------------------------------------------
module limit_order_matcher_core #(
   parameter int SYMBOLS        = 4,
   parameter int SLOTS_PER_SIDE = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lom_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lom_pkg::rsp_type rsp_data
);
   localparam int TOTAL = SYMBOLS * 2 * SLOTS_PER_SIDE;
   localparam int AW    = $clog2(TOTAL);
   localparam int CW    = $clog2(SLOTS_PER_SIDE + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_TRADE  = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // slot storage: valid in flops, payload in memories
   logic [TOTAL-1:0] valid_ff, valid_in;
   logic [31:0] mem_ident [TOTAL];
   logic [30:0] mem_qty   [TOTAL];
   logic [30:0] mem_price [TOTAL];
   logic [31:0] mem_stamp [TOTAL];

   logic [31:0] counter_ff, counter_in;
   lom_pkg::req_type ord_ff, ord_in;
   logic [2:0]  err_ff, err_in;
   logic [AW-1:0] opp_base_ff, opp_base_in, own_base_ff, own_base_in;

   // scan pipeline
   logic [CW-1:0] iss_ff, iss_in;
   logic          pv_ff, pv_in;
   logic [AW-1:0] paddr_ff, paddr_in, poaddr_ff, poaddr_in;
   logic          pvalid_ff, pvalid_in, pfree_ff, pfree_in;
   logic [31:0]   rd_ident_ff, rd_stamp_ff;
   logic [30:0]   rd_qty_ff, rd_price_ff;
   logic [AW-1:0] rd_addr;

   // best candidate and first free own slot
   lom_pkg::cand_type best_ff, best_in;
   logic [AW-1:0] best_addr_ff, best_addr_in;
   logic [30:0]   best_qty_ff, best_qty_in;
   logic [31:0]   best_ident_ff, best_ident_in;
   logic          free_ok_ff, free_ok_in;
   logic [AW-1:0] free_addr_ff, free_addr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   lom_pkg::rsp_type rsp_ff, rsp_in;

   lom_pkg::cand_type cand;
   logic              take;
   logic              out_free;
   logic [31:0]       tq;
   logic              wr_trade, wr_insert;
   logic [2:0]        new_err;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rd_addr   = opp_base_ff + AW'(iss_ff);

   always_comb begin
      cand.valid = pv_ff && pvalid_ff;
      cand.price = rd_price_ff;
      cand.age   = counter_ff - rd_stamp_ff;
   end

   lom_cmp u_cmp (
      .cand    (cand),
      .best    (best_ff),
      .is_sell (ord_ff.side[0]),
      .limit   (ord_ff.limit_price),
      .take    (take)
   );

   // validation, first failure wins
   always_comb begin
      if (req_data.order_ident == 32'd0)                  new_err = lom_pkg::ERR_BAD_ID;
      else if (req_data.side[1])                          new_err = lom_pkg::ERR_BAD_SIDE;
      else if (req_data.symbol_ident == 2'd0 ||
               32'(req_data.symbol_ident) >= 32'(SYMBOLS)) new_err = lom_pkg::ERR_BAD_SYM;
      else if (req_data.limit_price <= 0)                 new_err = lom_pkg::ERR_BAD_PRICE;
      else if (req_data.quantity <= 0)                    new_err = lom_pkg::ERR_BAD_QTY;
      else                                                new_err = lom_pkg::ERR_OK;
   end

   // fill size: lesser of what is left and what rests
   assign tq = (ord_ff.quantity < $signed({1'b0, best_qty_ff})) ?
               ord_ff.quantity : {1'b0, best_qty_ff};

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      counter_in    = counter_ff;
      ord_in        = ord_ff;
      err_in        = err_ff;
      opp_base_in   = opp_base_ff;
      own_base_in   = own_base_ff;
      iss_in        = iss_ff;
      pv_in         = 1'b0;
      paddr_in      = rd_addr;
      poaddr_in     = own_base_ff + AW'(iss_ff);
      pvalid_in     = valid_ff[rd_addr];
      pfree_in      = !valid_ff[own_base_ff + AW'(iss_ff)];
      best_in       = best_ff;
      best_addr_in  = best_addr_ff;
      best_qty_in   = best_qty_ff;
      best_ident_in = best_ident_ff;
      free_ok_in    = free_ok_ff;
      free_addr_in  = free_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      wr_trade      = 1'b0;
      wr_insert     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // stamp every order, valid or not
               counter_in  = counter_ff + 32'd1;
               ord_in      = req_data;
               err_in      = new_err;
               opp_base_in = AW'({req_data.symbol_ident, !req_data.side[0]} * SLOTS_PER_SIDE);
               own_base_in = AW'({req_data.symbol_ident, req_data.side[0]} * SLOTS_PER_SIDE);
               iss_in      = '0;
               best_in     = '0;
               free_ok_in  = 1'b0;
               state_in    = (new_err == lom_pkg::ERR_OK) ? ST_SCAN : ST_REPORT;
            end
         end
         ST_SCAN: begin
            // issue one slot read a cycle, compare in the next cycle
            if (iss_ff != CW'(SLOTS_PER_SIDE)) begin
               pv_in  = 1'b1;
               iss_in = iss_ff + CW'(1);
            end
            if (pv_ff && take) begin
               best_in       = cand;
               best_addr_in  = paddr_ff;
               best_qty_in   = rd_qty_ff;
               best_ident_in = rd_ident_ff;
            end
            if (pv_ff && pfree_ff && !free_ok_ff) begin
               free_ok_in   = 1'b1;
               free_addr_in = poaddr_ff;
            end
            if (iss_ff == CW'(SLOTS_PER_SIDE) && !pv_ff) begin
               if (best_ff.valid) begin
                  state_in = ST_TRADE;
               end else begin
                  // rest the remainder, or report a full book
                  if (free_ok_ff) begin
                     wr_insert              = 1'b1;
                     valid_in[free_addr_ff] = 1'b1;
                  end else begin
                     err_in = lom_pkg::ERR_BOOK_FULL;
                  end
                  state_in = ST_REPORT;
               end
            end
         end
         ST_TRADE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.result_type     = lom_pkg::RES_TRADE;
               rsp_in.out_symbol      = ord_ff.symbol_ident;
               rsp_in.out_order_ident = ord_ff.order_ident;
               rsp_in.resting_ident   = best_ident_ff;
               rsp_in.out_quantity    = tq;
               rsp_in.out_price       = {1'b0, best_ff.price};
               rsp_in.error_code      = lom_pkg::ERR_OK;
               rsp_in.is_last         = 1'b0;
               wr_trade               = 1'b1;
               if (tq == {1'b0, best_qty_ff}) valid_in[best_addr_ff] = 1'b0;
               ord_in.quantity = ord_ff.quantity - tq;
               iss_in     = '0;
               best_in    = '0;
               free_ok_in = 1'b0;
               state_in   = (ord_ff.quantity == tq) ? ST_REPORT : ST_SCAN;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.result_type     = lom_pkg::RES_INSERT;
               rsp_in.out_symbol      = ord_ff.symbol_ident;
               rsp_in.out_order_ident = ord_ff.order_ident;
               rsp_in.resting_ident   = 32'd0;
               rsp_in.out_quantity    = ord_ff.quantity;
               rsp_in.out_price       = ord_ff.limit_price;
               rsp_in.error_code      = err_ff;
               rsp_in.is_last         = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // slot memories: one read and one write port each
   always_ff @(posedge clock) begin
      rd_ident_ff <= mem_ident[rd_addr];
      rd_qty_ff   <= mem_qty[rd_addr];
      rd_price_ff <= mem_price[rd_addr];
      rd_stamp_ff <= mem_stamp[rd_addr];
      if (wr_trade) begin
         mem_qty[best_addr_ff] <= best_qty_ff - tq[30:0];
      end else if (wr_insert) begin
         mem_ident[free_addr_ff] <= ord_ff.order_ident;
         mem_qty[free_addr_ff]   <= ord_ff.quantity[30:0];
         mem_price[free_addr_ff] <= ord_ff.limit_price[30:0];
         mem_stamp[free_addr_ff] <= counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         counter_ff   <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff        <= ord_in;
      err_ff        <= err_in;
      opp_base_ff   <= opp_base_in;
      own_base_ff   <= own_base_in;
      iss_ff        <= iss_in;
      paddr_ff      <= paddr_in;
      poaddr_ff     <= poaddr_in;
      pvalid_ff     <= pvalid_in;
      pfree_ff      <= pfree_in;
      best_ff       <= best_in;
      best_addr_ff  <= best_addr_in;
      best_qty_ff   <= best_qty_in;
      best_ident_ff <= best_ident_in;
      free_ok_ff    <= free_ok_in;
      free_addr_ff  <= free_addr_in;
      rsp_ff        <= rsp_in;
   end

endmodule
